/* rtl/core/encoder_position_calibrate_core_macros.svh */
// Assertion macros shared by the encoder position calibration RTL.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ENCODER_POSITION_CALIBRATE_CORE_MACROS_SVH
`define ENCODER_POSITION_CALIBRATE_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define EPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, also evaluated while reset is asserted.
`define EPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/epc_pkg.sv */
// Package for the encoder position calibration core.
// Holds the register index codes and the fixed constants; depends on nothing.
package epc_pkg;

  localparam int unsigned CmWidth  = 16;
  localparam int unsigned QuoBits  = 16;
  localparam int unsigned GapCount = 1000;

  typedef enum logic [2:0] {
    CFG_MIN_COUNT = 3'd0,
    CFG_MAX_COUNT = 3'd1,
    CFG_MIN_CM    = 3'd2,
    CFG_MAX_CM    = 3'd3,
    CFG_OFFSET_CM = 3'd4
  } epc_cfg_e;

endpackage

/* rtl/core/encoder_position_calibrate_core.sv */
// Encoder position calibration core: two-point linear calibration of a raw count.
// Depends on epc_pkg and on encoder_position_calibrate_core_macros.svh.
//
// Each raw count request passes through a 20-stage pipeline: two stages for the
// inversion, span and distance clamp, one for the multiply, sixteen restoring
// divide stages giving one quotient bit each, and the output register. One request
// is accepted every cycle while the output is taken. A stall while a result waits
// at the output freezes the whole pipeline. Configuration writes are always ready
// and must only be issued while no request is in flight.
`include "encoder_position_calibrate_core_macros.svh"

module encoder_position_calibrate_core
  import epc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 30
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [2:0]                                    cfg_index_i,
  input  logic [((COUNT_BITS > 16) ? COUNT_BITS : 16)-1:0] cfg_data_i,
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  logic [COUNT_BITS-1:0]                         raw_count_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [CmWidth-1:0]                            position_cm_o
);

  localparam int unsigned C  = COUNT_BITS;
  localparam int unsigned GW = (C > 10) ? C : 10;
  localparam int unsigned PW = C + QuoBits;

  logic [C-1:0]       min_count_q, max_count_q;
  logic [CmWidth-1:0] min_cm_q, max_cm_q, offset_cm_q;

  logic advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q <= '0;
      max_count_q <= '1;
      min_cm_q    <= '0;
      max_cm_q    <= CmWidth'(1000);
      offset_cm_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_COUNT: min_count_q <= cfg_data_i[C-1:0];
        CFG_MAX_COUNT: max_count_q <= cfg_data_i[C-1:0];
        CFG_MIN_CM:    min_cm_q    <= cfg_data_i[CmWidth-1:0];
        CFG_MAX_CM:    max_cm_q    <= cfg_data_i[CmWidth-1:0];
        CFG_OFFSET_CM: offset_cm_q <= cfg_data_i[CmWidth-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: inversion, span and candidate distances.
  logic [C-1:0]  ri, mn, mx, span_d1, wrap_d1, direct_d1;
  logic [GW-1:0] mn_w, gap;
  logic          below_gap_d1, below_min_d1;

  always_comb begin
    ri   = ~raw_count_i;
    mn   = ~min_count_q;
    mx   = ~max_count_q;
    span_d1 = (mx > mn) ? (mx - mn) : (min_count_q + mx);
    mn_w = GW'(mn);
    gap  = (mn_w > GW'(GapCount)) ? (mn_w - GW'(GapCount)) : '0;
    below_gap_d1 = GW'(ri) < gap;
    below_min_d1 = ri < mn;
    wrap_d1   = min_count_q + ri;
    direct_d1 = ri - mn;
  end

  logic         s1_vld_q;
  logic [C-1:0] s1_span_q, s1_wrap_q, s1_direct_q;
  logic         s1_below_gap_q, s1_below_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_span_q      <= span_d1;
      s1_wrap_q      <= wrap_d1;
      s1_direct_q    <= direct_d1;
      s1_below_gap_q <= below_gap_d1;
      s1_below_min_q <= below_min_d1;
    end
  end

  // Stage 2: distance selection, clamp and slope magnitude.
  logic [C-1:0]       dist_sel, dist_d2;
  logic [CmWidth:0]   dy;
  logic [CmWidth-1:0] mag_d2;

  always_comb begin
    priority if (s1_below_gap_q) begin
      dist_sel = s1_wrap_q;
    end else if (s1_below_min_q) begin
      dist_sel = '0;
    end else begin
      dist_sel = s1_direct_q;
    end
    dist_d2 = (dist_sel > s1_span_q) ? s1_span_q : dist_sel;
    dy      = {1'b0, max_cm_q} - {1'b0, min_cm_q};
    mag_d2  = dy[CmWidth] ? CmWidth'(-dy) : dy[CmWidth-1:0];
  end

  logic               s2_vld_q, s2_neg_q, s2_zero_q;
  logic [C-1:0]       s2_dist_q, s2_span_q;
  logic [CmWidth-1:0] s2_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_dist_q <= dist_d2;
      s2_span_q <= s1_span_q;
      s2_zero_q <= (s1_span_q == '0);
      s2_neg_q  <= dy[CmWidth];
      s2_mag_q  <= mag_d2;
    end
  end

  // Stage 3: product, then sixteen restoring divide stages.
  logic [PW-1:0] prod;
  assign prod = PW'(s2_dist_q) * PW'(s2_mag_q);

  logic               div_vld_q  [QuoBits+1];
  logic               div_neg_q  [QuoBits+1];
  logic               div_zero_q [QuoBits+1];
  logic [C-1:0]       div_span_q [QuoBits+1];
  logic [C-1:0]       div_rem_q  [QuoBits+1];
  logic [QuoBits-1:0] div_bits_q [QuoBits+1];

  logic [C-1:0]       div_rem_d  [QuoBits];
  logic [QuoBits-1:0] div_bits_d [QuoBits];

  always_comb begin
    logic [C:0] trial;
    logic       ge;
    for (int s = 0; s < QuoBits; s++) begin
      trial = {div_rem_q[s], div_bits_q[s][QuoBits-1]};
      ge    = trial >= {1'b0, div_span_q[s]};
      div_rem_d[s]  = ge ? C'(trial - {1'b0, div_span_q[s]}) : trial[C-1:0];
      div_bits_d[s] = {div_bits_q[s][QuoBits-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QuoBits; s++) begin
        div_vld_q[s] <= 1'b0;
      end
    end else if (advance) begin
      div_vld_q[0] <= s2_vld_q;
      for (int s = 0; s < QuoBits; s++) begin
        div_vld_q[s+1] <= div_vld_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      div_rem_q[0]  <= prod[PW-1:QuoBits];
      div_bits_q[0] <= prod[QuoBits-1:0];
      div_span_q[0] <= s2_span_q;
      div_zero_q[0] <= s2_zero_q;
      div_neg_q[0]  <= s2_neg_q;
      for (int s = 0; s < QuoBits; s++) begin
        div_rem_q[s+1]  <= div_rem_d[s];
        div_bits_q[s+1] <= div_bits_d[s];
        div_span_q[s+1] <= div_span_q[s];
        div_zero_q[s+1] <= div_zero_q[s];
        div_neg_q[s+1]  <= div_neg_q[s];
      end
    end
  end

  // Output stage: apply sign, add the lower point and the offset.
  logic [CmWidth-1:0] quo, step, pos_d;
  logic               out_vld_q;
  logic [CmWidth-1:0] out_pos_q;

  always_comb begin
    quo   = div_bits_q[QuoBits];
    step  = div_zero_q[QuoBits] ? '0 : (div_neg_q[QuoBits] ? CmWidth'(-quo) : quo);
    pos_d = min_cm_q + step + offset_cm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= div_vld_q[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pos_q <= pos_d;
    end
  end

  assign advance       = !out_vld_q || !out_stall_i;
  assign in_stall_o    = !advance;
  assign out_valid_o   = out_vld_q;
  assign position_cm_o = out_pos_q;

  `EPC_ASSERT(a_stall_only_when_blocked, in_stall_o |-> (out_vld_q && out_stall_i), "stall without blocked output")
  `EPC_ASSERT(a_accept_enters, (in_valid_i && !in_stall_o) |=> s1_vld_q, "accepted request lost at entry")
  `EPC_ASSERT(a_dist_clamped, s2_vld_q |-> (s2_dist_q <= s2_span_q), "distance exceeds span")
  `EPC_ASSERT(a_div_first_rem, (div_vld_q[0] && !div_zero_q[0]) |-> (div_rem_q[0] < div_span_q[0]), "divider input overflows quotient width")
  `EPC_ASSERT(a_div_last_rem, (div_vld_q[QuoBits] && !div_zero_q[QuoBits]) |-> (div_rem_q[QuoBits] < div_span_q[QuoBits]), "divider remainder not below span")

endmodule

/* test/encoder_position_calibrate_core_test.sv */
// Self-checking testbench for encoder_position_calibrate_core: raw counts are sent
// through the pipeline and each position is compared with a built-in calculation.
// Depends on epc_pkg and on the core RTL.
module encoder_position_calibrate_core_test;
  import epc_pkg::*;

  localparam int unsigned CountBits = 30;
  localparam int unsigned DataBits  = (CountBits > 16) ? CountBits : 16;
  localparam int unsigned Latency   = 20;
  localparam longint      CountMax  = (longint'(1) << CountBits) - 1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [2:0]           cfg_index_i;
  logic [DataBits-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CountBits-1:0] raw_count_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CmWidth-1:0]   position_cm_o;

  logic [CountBits-1:0] cal_min_count;
  logic [CountBits-1:0] cal_max_count;
  logic [CmWidth-1:0]   cal_min_cm;
  logic [CmWidth-1:0]   cal_max_cm;
  logic [CmWidth-1:0]   cal_offset_cm;

  logic [CmWidth-1:0] position_q[$];
  int                 err_count;
  int                 hold_off_req;
  bit                 calm;

  encoder_position_calibrate_core #(
    .COUNT_BITS(CountBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_count_i  (raw_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_cm_o(position_cm_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [CmWidth-1:0] calc_position(logic [CountBits-1:0] raw);
    longint ri, mn, mx, span, gap, dcount, dy, scaled;
    logic [CmWidth-1:0] pos;
    ri = CountMax - longint'(raw);
    mn = CountMax - longint'(cal_min_count);
    mx = CountMax - longint'(cal_max_count);
    span = (mx > mn) ? (mx - mn) : (CountMax - mn + mx);
    gap = (mn > longint'(GapCount)) ? (mn - longint'(GapCount)) : 0;
    if (ri < gap) begin
      dcount = CountMax - mn + ri;
    end else if (ri < mn) begin
      dcount = 0;
    end else begin
      dcount = ri - mn;
    end
    if (dcount > span) dcount = span;
    if (span == 0) begin
      scaled = longint'(cal_min_cm);
    end else begin
      dy = longint'(cal_max_cm) - longint'(cal_min_cm);
      scaled = longint'(cal_min_cm) + (dcount * dy) / span;
    end
    pos = scaled[CmWidth-1:0];
    return pos + cal_offset_cm;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CountBits-1:0] pick_raw();
    int r;
    logic [CountBits-1:0] lo, hi;
    r = $urandom_range(0, 99);
    lo = (cal_min_count < cal_max_count) ? cal_min_count : cal_max_count;
    hi = (cal_min_count < cal_max_count) ? cal_max_count : cal_min_count;
    if (r < 25) return CountBits'($urandom);
    if (r < 50) return CountBits'(cal_min_count + $urandom_range(0, 3000) - 1500);
    if (r < 65) return CountBits'(cal_max_count + $urandom_range(0, 3000) - 1500);
    if (r < 92) return CountBits'(lo + ($urandom % (32'(hi - lo) + 1)));
    return ($urandom_range(0, 1) == 0) ? '0 : CountBits'(CountMax);
  endfunction

  always @(posedge clk_i) begin : check_position
    logic [CmWidth-1:0] exp_pos;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (position_q.size() == 0) begin
        $error("position_cm: result with no request waiting, actual %0d", position_cm_o);
        err_count++;
      end else begin
        exp_pos = position_q.pop_front();
        if (position_cm_o !== exp_pos) begin
          $error("position_cm: expected %0d, actual %0d", exp_pos, position_cm_o);
          err_count++;
        end
      end
    end
  end

  initial begin : drive_stall
    int stall_left, free_left;
    stall_left = 0;
    free_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req > 0) begin
        stall_left = hold_off_req;
        free_left = 0;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (calm || free_left > 0) begin
        out_stall_i = 1'b0;
        if (free_left > 0) free_left--;
      end else begin
        stall_left = pick_gap();
        free_left = $urandom_range(1, 12);
        out_stall_i = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic post_raw(logic [CountBits-1:0] raw);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    raw_count_i = raw;
    do @(posedge clk_i); while (in_stall_o);
    position_q.push_back(calc_position(raw));
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (position_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [DataBits-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_COUNT: cal_min_count = data[CountBits-1:0];
      CFG_MAX_COUNT: cal_max_count = data[CountBits-1:0];
      CFG_MIN_CM:    cal_min_cm = data[CmWidth-1:0];
      CFG_MAX_CM:    cal_max_cm = data[CmWidth-1:0];
      CFG_OFFSET_CM: cal_offset_cm = data[CmWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_calibration(logic [CountBits-1:0] min_count,
                                   logic [CountBits-1:0] max_count,
                                   logic [CmWidth-1:0] min_cm, logic [CmWidth-1:0] max_cm,
                                   logic [CmWidth-1:0] offset_cm);
    drain_pipeline();
    write_reg(CFG_MIN_COUNT, DataBits'(min_count));
    write_reg(CFG_MAX_COUNT, DataBits'(max_count));
    write_reg(CFG_MIN_CM, {(DataBits - CmWidth)'($urandom), min_cm});
    write_reg(CFG_MAX_CM, {(DataBits - CmWidth)'($urandom), max_cm});
    write_reg(CFG_OFFSET_CM, {(DataBits - CmWidth)'($urandom), offset_cm});
  endtask

  task automatic set_random_calibration();
    logic [CountBits-1:0] mn, mx;
    logic [CmWidth-1:0] lo_cm, hi_cm;
    mn = CountBits'($urandom);
    case ($urandom_range(0, 4))
      0: mx = CountBits'($urandom);
      1, 2: mx = CountBits'(mn - $urandom_range(1, 200000));
      3: mx = mn;
      default: begin
        mn = CountBits'(CountMax - $urandom_range(0, 1500));
        mx = CountBits'($urandom_range(0, 100000));
      end
    endcase
    lo_cm = ($urandom_range(0, 3) == 0) ? '0 : CmWidth'($urandom);
    hi_cm = ($urandom_range(0, 3) == 0) ? '1 : CmWidth'($urandom);
    write_calibration(mn, mx, lo_cm, hi_cm, CmWidth'($urandom));
  endtask

  task automatic test_reset_calibration();
    post_raw('0);
    post_raw(CountBits'(CountMax));
    post_raw(CountBits'(12345));
  endtask

  task automatic test_interpolation();
    write_calibration(CountBits'(5000), CountBits'(1000), 16'd100, 16'd900, 16'd0);
    post_raw(CountBits'(5000));
    post_raw(CountBits'(5001));
    post_raw(CountBits'(6000));
    post_raw(CountBits'(6001));
    post_raw(CountBits'(3000));
    post_raw(CountBits'(1000));
    post_raw(CountBits'(999));
    post_raw('0);
  endtask

  task automatic test_equal_counts();
    write_calibration(CountBits'(20000), CountBits'(20000), 16'd10, 16'd5000, 16'd7);
    post_raw(CountBits'(20000));
    post_raw(CountBits'(10000));
    post_raw(CountBits'(30000));
  endtask

  task automatic test_cm_extremes();
    write_calibration(CountBits'(CountMax), '0, 16'hFFFF, 16'h0000, 16'h8000);
    post_raw('0);
    post_raw(CountBits'(CountMax));
    post_raw(CountBits'(1 << 29));
    write_calibration(CountBits'(CountMax), '0, 16'h0000, 16'hFFFF, 16'h7FFF);
    post_raw(CountBits'(CountMax));
    post_raw('0);
  endtask

  task automatic test_minimum_near_top();
    write_calibration(CountBits'(CountMax - 500), CountBits'(100), 16'd0, 16'd1000, 16'hFFFF);
    drain_pipeline();
    write_reg(CFG_OFFSET_CM + 3'd1, DataBits'($urandom));
    write_reg(CFG_OFFSET_CM + 3'd2, DataBits'($urandom));
    write_reg(CFG_OFFSET_CM + 3'd3, DataBits'($urandom));
    post_raw(CountBits'(CountMax));
    post_raw(CountBits'(CountMax - 500));
    post_raw(CountBits'(50));
  endtask

  task automatic test_random_calibrations();
    repeat (9) begin
      set_random_calibration();
      repeat (90) post_raw(pick_raw());
    end
  endtask

  task automatic test_back_pressure();
    set_random_calibration();
    drain_pipeline();
    calm = 1'b1;
    hold_off_req = 300;
    repeat (120) post_raw(pick_raw());
    calm = 1'b0;
  endtask

  task automatic test_full_rate();
    set_random_calibration();
    drain_pipeline();
    calm = 1'b1;
    repeat (80) post_raw(pick_raw());
    calm = 1'b0;
  endtask

  initial begin
    err_count = 0;
    hold_off_req = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MIN_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    raw_count_i = '0;
    cal_min_count = '0;
    cal_max_count = CountBits'(CountMax);
    cal_min_cm = '0;
    cal_max_cm = CmWidth'(1000);
    cal_offset_cm = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_calibration();
    test_interpolation();
    test_equal_counts();
    test_cm_extremes();
    test_minimum_near_top();
    test_random_calibrations();
    test_back_pressure();
    test_full_rate();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (position_q.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
